// File: sv/text_console_cursor_scroll_assert.svh
// Assertion macros used by the text console sequencer.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TCON_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TCON_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/tcon_pkg.sv
// Shared constants, types and codes of the text console.
package tcon_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int ROW_W      = 5;
	localparam int COL_W      = 7;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] COLOR_RESET  = 8'd10;

	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_BKSP  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic [7:0] color;
		logic [7:0] code;
	} cell_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		cell_t wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

endpackage

// File: sv/tcon_store.sv
// Frame store: one write port and one registered read port.
module tcon_store (
	input  logic              clk,
	input  tcon_pkg::mem_req_t req,
	output tcon_pkg::cell_t   rdata
);

	tcon_pkg::cell_t mem [tcon_pkg::CELL_COUNT];
	tcon_pkg::cell_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/tcon_ctrl.sv
// Sequencer: cursor, colour register, command decode and the sweep over the store.
`include "text_console_cursor_scroll_assert.svh"

module tcon_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [1:0]                   mode,
	input  logic [7:0]                   char_code,
	input  logic [tcon_pkg::ROW_W-1:0]   read_row,
	input  logic [tcon_pkg::COL_W-1:0]   read_col,
	input  logic                         cfg_valid,
	input  logic [7:0]                   cfg_data,
	input  tcon_pkg::cell_t              rdata,
	output tcon_pkg::mem_req_t           req,
	output logic                         busy,
	output logic                         done,
	output logic [7:0]                   cell_char,
	output logic [7:0]                   cell_color,
	output logic [tcon_pkg::ROW_W-1:0]   cursor_row,
	output logic [tcon_pkg::COL_W-1:0]   cursor_col,
	output logic                         scrolled
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_RDWAIT = 3'd2;
	localparam logic [2:0] S_SWEEP  = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;

	localparam tcon_pkg::addr_t COLS_A     = tcon_pkg::ADDR_W'(tcon_pkg::COLUMNS);
	localparam tcon_pkg::addr_t COPY_A     = tcon_pkg::ADDR_W'(tcon_pkg::COPY_COUNT);
	localparam tcon_pkg::addr_t LAST_A     = tcon_pkg::ADDR_W'(tcon_pkg::CELL_COUNT - 1);
	localparam tcon_pkg::addr_t LAST_ROW_A = tcon_pkg::ADDR_W'(tcon_pkg::COPY_COUNT);
	localparam logic [tcon_pkg::ROW_W-1:0] LAST_ROW = tcon_pkg::ROW_W'(tcon_pkg::ROWS - 1);
	localparam logic [tcon_pkg::COL_W-1:0] LAST_COL = tcon_pkg::COL_W'(tcon_pkg::COLUMNS - 1);

	logic [2:0]                 state_q;
	logic [1:0]                 mode_q;
	logic [7:0]                 char_q;
	logic [tcon_pkg::ROW_W-1:0] rrow_q;
	logic [tcon_pkg::COL_W-1:0] rcol_q;
	logic [7:0]                 color_q;
	logic [tcon_pkg::ROW_W-1:0] row_q;
	logic [tcon_pkg::COL_W-1:0] col_q;
	tcon_pkg::addr_t            cur_addr_q;
	tcon_pkg::addr_t            idx_q;
	logic                       copy_q;
	logic                       init_q;
	logic                       in_range_q;
	logic                       done_q;
	logic                       scrolled_q;
	logic [7:0]                 cell_char_q;
	logic [7:0]                 cell_color_q;
	logic                       pend_s1;
	tcon_pkg::addr_t            addr_s1;
	logic                       blank_s1;

	logic [tcon_pkg::ROW_W-1:0] nx_row;
	logic [tcon_pkg::COL_W-1:0] nx_col;
	tcon_pkg::addr_t            nx_addr;
	logic                       nx_scroll;
	tcon_pkg::addr_t            rd_addr;
	logic                       in_range;
	tcon_pkg::cell_t            blank_cell;

	// Cursor update and read address for the command held in EXEC.
	always_comb begin
		nx_row    = row_q;
		nx_col    = col_q;
		nx_addr   = cur_addr_q;
		nx_scroll = 1'b0;
		rd_addr   = tcon_pkg::ADDR_W'(rrow_q) * COLS_A + tcon_pkg::ADDR_W'(rcol_q);
		in_range  = (32'(rrow_q) < 32'(tcon_pkg::ROWS)) &&
			(32'(rcol_q) < 32'(tcon_pkg::COLUMNS));
		case (mode_q)
			tcon_pkg::MODE_PUT: begin
				if (char_q == tcon_pkg::NEWLINE_CODE || col_q == LAST_COL) begin
					nx_col = '0;
					if (row_q == LAST_ROW) begin
						nx_scroll = 1'b1;
						nx_addr   = LAST_ROW_A;
					end else begin
						nx_row  = row_q + 1'b1;
						nx_addr = cur_addr_q - tcon_pkg::ADDR_W'(col_q) + COLS_A;
					end
				end else begin
					nx_col  = col_q + 1'b1;
					nx_addr = cur_addr_q + 1'b1;
				end
			end
			tcon_pkg::MODE_BKSP: begin
				if (cur_addr_q != '0) begin
					nx_addr = cur_addr_q - 1'b1;
					if (col_q == '0) begin
						nx_row = row_q - 1'b1;
						nx_col = LAST_COL;
					end else begin
						nx_col = col_q - 1'b1;
					end
				end
			end
			tcon_pkg::MODE_CLEAR: begin
				nx_row  = '0;
				nx_col  = '0;
				nx_addr = '0;
			end
			default: begin
			end
		endcase
	end

	// Store port: the sweep's delayed write has the port whenever it is pending.
	always_comb begin
		blank_cell.code  = tcon_pkg::SPACE_CODE;
		blank_cell.color = init_q ? tcon_pkg::COLOR_RESET : color_q;
		req.we    = 1'b0;
		req.waddr = addr_s1;
		req.wdata = blank_cell;
		req.re    = 1'b0;
		req.raddr = rd_addr;
		if (pend_s1) begin
			req.we    = 1'b1;
			req.wdata = blank_s1 ? blank_cell : rdata;
		end else if (state_q == S_EXEC) begin
			if (mode_q == tcon_pkg::MODE_PUT && char_q != tcon_pkg::NEWLINE_CODE) begin
				req.we          = 1'b1;
				req.waddr       = cur_addr_q;
				req.wdata.code  = char_q;
				req.wdata.color = color_q;
			end else if (mode_q == tcon_pkg::MODE_BKSP && cur_addr_q != '0) begin
				req.we          = 1'b1;
				req.waddr       = cur_addr_q - 1'b1;
				req.wdata.code  = tcon_pkg::SPACE_CODE;
				req.wdata.color = color_q;
			end
		end
		if (state_q == S_SWEEP && copy_q && idx_q < COPY_A) begin
			req.re    = 1'b1;
			req.raddr = idx_q + COLS_A;
		end else if (state_q == S_EXEC && mode_q == tcon_pkg::MODE_READ) begin
			req.re = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			mode_q       <= tcon_pkg::MODE_PUT;
			char_q       <= '0;
			rrow_q       <= '0;
			rcol_q       <= '0;
			in_range_q   <= 1'b0;
			addr_s1      <= '0;
			blank_s1     <= 1'b0;
			idx_q        <= '0;
			copy_q       <= 1'b0;
			init_q       <= 1'b1;
			pend_s1      <= 1'b0;
			done_q       <= 1'b0;
			color_q      <= tcon_pkg::COLOR_RESET;
			row_q        <= '0;
			col_q        <= '0;
			cur_addr_q   <= '0;
			scrolled_q   <= 1'b0;
			cell_char_q  <= '0;
			cell_color_q <= '0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
			if (cfg_valid) begin
				color_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						char_q  <= char_code;
						rrow_q  <= read_row;
						rcol_q  <= read_col;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					row_q        <= nx_row;
					col_q        <= nx_col;
					cur_addr_q   <= nx_addr;
					scrolled_q   <= nx_scroll;
					cell_char_q  <= '0;
					cell_color_q <= '0;
					idx_q        <= '0;
					case (mode_q)
						tcon_pkg::MODE_PUT: begin
							if (nx_scroll) begin
								copy_q  <= 1'b1;
								state_q <= S_SWEEP;
							end else begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end
						end
						tcon_pkg::MODE_CLEAR: begin
							copy_q  <= 1'b0;
							state_q <= S_SWEEP;
						end
						tcon_pkg::MODE_READ: begin
							in_range_q <= in_range;
							state_q    <= S_RDWAIT;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_RDWAIT: begin
					if (in_range_q) begin
						cell_char_q  <= rdata.code;
						cell_color_q <= rdata.color;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					pend_s1  <= 1'b1;
					addr_s1  <= idx_q;
					blank_s1 <= !copy_q || idx_q >= COPY_A;
					idx_q    <= idx_q + 1'b1;
					if (idx_q == LAST_A) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					done_q  <= !init_q;
					init_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign cell_char  = cell_char_q;
	assign cell_color = cell_color_q;
	assign cursor_row = row_q;
	assign cursor_col = col_q;
	assign scrolled   = scrolled_q;

	`TCON_ASSERT_NOW(a_done_idle, done_q, state_q == S_IDLE, "result strobe while busy")
	`TCON_ASSERT_NEXT(a_start_exec, state_q == S_IDLE && start, state_q == S_EXEC,
		"accepted command not executed")
	`TCON_ASSERT_NOW(a_no_port_clash, state_q == S_EXEC, !pend_s1,
		"sweep write pending during command execution")
	`TCON_ASSERT_NOW(a_cursor_range, 1'b1,
		32'(row_q) < 32'(tcon_pkg::ROWS) && 32'(col_q) < 32'(tcon_pkg::COLUMNS),
		"cursor outside the screen")
	`TCON_ASSERT_NOW(a_addr_match, state_q == S_IDLE,
		cur_addr_q == tcon_pkg::ADDR_W'(row_q) * COLS_A + tcon_pkg::ADDR_W'(col_q),
		"cursor address out of step with row and column")

endmodule

// File: sv/text_console_cursor_scroll.sv
// Top level of the character-cell text console.
//
// Commands enter on start, accepted at a rising edge with start high and busy low. The
// fields are mode (put character, backspace, clear, read cell), char_code, read_row and
// read_col. Every command produces exactly one result transfer: done is high for a single
// cycle while cell_char, cell_color, cursor_row, cursor_col and scrolled hold the result.
// The receiver cannot stall; the result is taken in that cycle and busy is already low.
// The colour register is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high and the new colour applies to cells written after the transfer.
// Put without scrolling and backspace pass through EXEC to the result strobe; a read
// passes through EXEC and RDWAIT. Clear and any put that scrolls pass through EXEC,
// SWEEP and DRAIN and walk the whole store through one read port and one write port,
// one cell per cycle. After reset the store is filled with spaces in the reset colour
// by the same sweep; busy stays high until it ends and no result is produced for it.
module text_console_cursor_scroll (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 mode,
	input  logic [7:0]                 char_code,
	input  logic [tcon_pkg::ROW_W-1:0] read_row,
	input  logic [tcon_pkg::COL_W-1:0] read_col,
	output logic                       done,
	output logic [7:0]                 cell_char,
	output logic [7:0]                 cell_color,
	output logic [tcon_pkg::ROW_W-1:0] cursor_row,
	output logic [tcon_pkg::COL_W-1:0] cursor_col,
	output logic                       scrolled,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [7:0]                 cfg_data
);

	tcon_pkg::mem_req_t req;
	tcon_pkg::cell_t    rdata;

	// The colour register never refuses a transfer.
	assign cfg_ready = 1'b1;

	// Sequencer: holds the cursor and colour, and drives the store for single
	// cell accesses as well as the whole-store sweep used by scroll and clear.
	tcon_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.mode       (mode),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.rdata      (rdata),
		.req        (req),
		.busy       (busy),
		.done       (done),
		.cell_char  (cell_char),
		.cell_color (cell_color),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col),
		.scrolled   (scrolled)
	);

	// Frame store with registered read data; a scroll copies each cell one row up
	// by reading it in one cycle and writing it in the next.
	tcon_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

endmodule
